// ===== rtl/uuid_text_parser_assert.svh =====
// ---------------------------------------------------------------------------
// uuid_text_parser_assert.svh
// Assertion macros for the UUID text parser; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_ASSERT_SVH
`define UUID_TEXT_PARSER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define UTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uuid_text_parser: assertion failed");
// Next-cycle implication, checked out of reset
`define UTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uuid_text_parser: assertion failed");
`else
`define UTP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UTP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/uuid_pkg.sv =====
// ---------------------------------------------------------------------------
// uuid_pkg
// Character codes, length limits and the hex digit decoder of the parser.
// ---------------------------------------------------------------------------
package uuid_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  localparam logic [5:0] LEN_BRACED = 6'd38;
  localparam logic [5:0] LEN_PLAIN  = 6'd36;
  localparam logic [5:0] COUNT_MAX  = 6'd63;
  localparam logic [4:0] UUID_BYTES = 5'd16;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  // decode one ASCII character as a hex digit
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok  = 1'b1;
    d.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d.nib = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== rtl/uuid_text_parser.sv =====
// ---------------------------------------------------------------------------
// uuid_text_parser
// Parses the text form of a UUID, one character per word, into 128 bits.
// ---------------------------------------------------------------------------
// The block takes one character word per clock and answers each text, on
// the word flagged last_char, with one result word: valid_res and the
// 128-bit value (byte 0 in the top bits of value_high), all zero when the
// text does not parse. A leading '{' selects the braced form, which must
// be 38 characters and end in '}'; the plain form must be 36 characters.
// Hex pairs give the bytes, high nibble first, one '-' may follow any
// byte, and characters after the sixteenth byte are ignored. Throughput is
// one character per cycle with no gaps between texts; a last character
// passes through the input register and the single parse stage into the
// result register. Back-pressure on the result side stalls the input only
// once the result register is full and the parse stage holds a word.
`include "uuid_text_parser_assert.svh"

module uuid_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [63:0] out_value_high,
  output logic [63:0] out_value_low
);

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // parse state
  logic [127:0] value_r,     value_nxt;
  logic [4:0]   bytes_r,     bytes_nxt;
  logic         phase_r,     phase_nxt;
  logic [3:0]   held_r,      held_nxt;
  logic [5:0]   char_cnt_r,  char_cnt_nxt;
  logic         brace_r,     brace_nxt;
  logic         after_r,     after_nxt;
  logic         err_r,       err_nxt;

  // result register
  logic        out_valid_r;
  logic        res_ok_r,  res_ok_nxt;
  logic [63:0] res_hi_r,  res_hi_nxt;
  logic [63:0] res_lo_r,  res_lo_nxt;

  logic               fire;
  uuid_pkg::hex_digit_t dig;

  // The parse stage fires when it holds a word and the result register can
  // take a new result (empty, or being emptied this cycle).
  assign fire     = in_v_r && (!out_valid_r || !out_stall);
  assign in_stall = in_v_r && !fire;

  assign dig = uuid_pkg::hex_decode(in_char_r);

  always_comb begin
    value_nxt    = value_r;
    bytes_nxt    = bytes_r;
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    brace_nxt    = brace_r;
    after_nxt    = after_r;
    err_nxt      = err_r;
    char_cnt_nxt = (char_cnt_r == uuid_pkg::COUNT_MAX) ? char_cnt_r : char_cnt_r + 6'd1;
    res_ok_nxt   = 1'b0;
    res_hi_nxt   = 64'd0;
    res_lo_nxt   = 64'd0;

    if (char_cnt_r == 6'd0 && in_char_r == uuid_pkg::CH_OPEN) begin
      brace_nxt = 1'b1;
    end else if (!err_r && bytes_r < uuid_pkg::UUID_BYTES) begin
      after_nxt = 1'b0;
      // skip one dash straight after a completed byte
      if (!(after_r && in_char_r == uuid_pkg::CH_DASH)) begin
        if (!dig.ok) begin
          err_nxt = 1'b1;
        end else if (!phase_r) begin
          held_nxt  = dig.nib;
          phase_nxt = 1'b1;
        end else begin
          // bytes arrive in order, so shift each one in at the bottom
          value_nxt = {value_r[119:0], held_r, dig.nib};
          bytes_nxt = bytes_r + 5'd1;
          phase_nxt = 1'b0;
          held_nxt  = 4'd0;
          after_nxt = 1'b1;
        end
      end
    end

    if (in_last_r) begin
      res_ok_nxt = !err_nxt && bytes_nxt == uuid_pkg::UUID_BYTES;
      if (brace_nxt) begin
        res_ok_nxt = res_ok_nxt && char_cnt_nxt == uuid_pkg::LEN_BRACED
                     && in_char_r == uuid_pkg::CH_CLOSE;
      end else begin
        res_ok_nxt = res_ok_nxt && char_cnt_nxt == uuid_pkg::LEN_PLAIN;
      end
      res_hi_nxt = res_ok_nxt ? value_nxt[127:64] : 64'd0;
      res_lo_nxt = res_ok_nxt ? value_nxt[63:0]   : 64'd0;
      // clear everything for the next text
      value_nxt    = 128'd0;
      bytes_nxt    = 5'd0;
      phase_nxt    = 1'b0;
      held_nxt     = 4'd0;
      char_cnt_nxt = 6'd0;
      brace_nxt    = 1'b0;
      after_nxt    = 1'b0;
      err_nxt      = 1'b0;
    end
  end

  // input register: load whenever the stage is free or firing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_code;
      in_last_r <= in_last_char;
    end
  end

  // parse state: advance on each fired word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r    <= 128'd0;
      bytes_r    <= 5'd0;
      phase_r    <= 1'b0;
      held_r     <= 4'd0;
      char_cnt_r <= 6'd0;
      brace_r    <= 1'b0;
      after_r    <= 1'b0;
      err_r      <= 1'b0;
    end else if (fire) begin
      value_r    <= value_nxt;
      bytes_r    <= bytes_nxt;
      phase_r    <= phase_nxt;
      held_r     <= held_nxt;
      char_cnt_r <= char_cnt_nxt;
      brace_r    <= brace_nxt;
      after_r    <= after_nxt;
      err_r      <= err_nxt;
    end
  end

  // result register: load on a fired last character, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_r) begin
      res_ok_r <= res_ok_nxt;
      res_hi_r <= res_hi_nxt;
      res_lo_r <= res_lo_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_ok_r;
  assign out_value_high = res_hi_r;
  assign out_value_low  = res_lo_r;

  // a failed text carries a zero value
  `UTP_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid_r && !res_ok_r,
                  res_hi_r == 64'd0 && res_lo_r == 64'd0)
  // never more than sixteen bytes collected
  `UTP_ASSERT_IMP(a_bytes_bound, clk, rst_n, 1'b1, bytes_r <= uuid_pkg::UUID_BYTES)
  // the state is clear after a text ends
  `UTP_ASSERT_NXT(a_clear_after_last, clk, rst_n, fire && in_last_r,
                  char_cnt_r == 6'd0 && bytes_r == 5'd0 && !err_r)
  // input stalls only with a word held behind a full, stalled result
  `UTP_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall,
                  in_v_r && out_valid_r && out_stall)

endmodule
